// ===== design/urx_pkg.sv =====
package urx_pkg;

  localparam logic [63:0] DefaultSeed = 64'h4d59_5df4_d0f3_3173;
  localparam logic [63:0] MixMult     = 64'd2685821657736338717;
  localparam int unsigned ShiftA      = 12;
  localparam int unsigned ShiftB      = 25;
  localparam int unsigned ShiftC      = 27;
  localparam int unsigned WordW       = 64;
  localparam int unsigned SpanW       = 33;
  localparam int unsigned CntW        = $clog2(WordW);

  typedef enum logic {
    CmdDraw   = 1'b0,
    CmdReseed = 1'b1
  } urx_cmd_e;

  typedef enum logic [2:0] {
    UrxIdle,
    UrxStep,
    UrxMul,
    UrxMod,
    UrxEmit
  } urx_state_e;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [63:0]        seed_value;
  } urx_in_t;

  typedef struct packed {
    logic signed [31:0] drawn_value;
    logic [63:0]        state_now;
    logic [63:0]        seed_now;
    logic [63:0]        draw_total;
  } urx_out_t;

  typedef struct packed {
    logic mul_busy;
    logic rem_busy;
  } urx_stat_t;

  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> ShiftA);
    t = t ^ (t << ShiftB);
    t = t ^ (t >> ShiftC);
    return t;
  endfunction

endpackage

// ===== design/urx_rem.sv =====
module urx_rem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [urx_pkg::WordW-1:0]    dividend_i,
  input  logic [urx_pkg::SpanW-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [urx_pkg::SpanW-1:0]    rem_o
);

  logic                      busy_q, busy_d;
  logic [urx_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [urx_pkg::WordW-1:0] dvd_q, dvd_d;
  logic [urx_pkg::SpanW-1:0] div_q, div_d;
  logic [urx_pkg::SpanW-1:0] rem_q, rem_d;
  logic [urx_pkg::SpanW:0]   trial;
  logic [urx_pkg::SpanW:0]   diff;

  always_comb begin
    trial  = {rem_q, dvd_q[urx_pkg::WordW-1]};
    diff   = trial - {1'b0, div_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[urx_pkg::WordW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[urx_pkg::SpanW-1:0];
      end else begin
        rem_d = trial[urx_pkg::SpanW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == urx_pkg::CntW'(urx_pkg::WordW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/urx_mul.sv =====
module urx_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [urx_pkg::WordW-1:0] mcand_i,
  output logic                      busy_o,
  output logic [urx_pkg::WordW-1:0] word_o
);

  logic                      busy_q, busy_d;
  logic [urx_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [urx_pkg::WordW-1:0] mcand_q, mcand_d;
  logic [urx_pkg::WordW-1:0] acc_q, acc_d;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      mcand_d = mcand_i;
      acc_d   = '0;
    end else if (busy_q) begin
      if (urx_pkg::MixMult[cnt_q]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d = {mcand_q[urx_pkg::WordW-2:0], 1'b0};
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == urx_pkg::CntW'(urx_pkg::WordW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

  assign busy_o = busy_q;
  assign word_o = acc_q;

endmodule

// ===== design/uniform_range_xorshift64star.sv =====
// Uniform integer range draw on a 64-bit xorshift64* generator.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one command item:
// a reseed loads the seed (zero selects the default), sets the state to it
// and clears the step count; a draw returns an integer spread evenly over
// the inclusive range of the two bounds, in either order.
// Output channel (out_valid_o/out_ready_i, out_data_o) gives one item per
// command, with the state, seed and step count after it.
// Sequence: a reseed passes through the emit state into the output
// register. A draw runs one or more generator steps, usually a single
// step: each generator step is a state update followed by a product on a
// bit-serial shift-add multiplier, the rejection threshold is found on the
// bit-serial remainder unit alongside the first step, and the final
// reduction reuses that unit, then the output register is loaded.
// One item is in work at a time; in_ready_o is high only when idle, so the
// next item is taken the cycle after the result is loaded.
// At reset the state and seed take the default seed, the count is zero and
// the output register is empty. When the receiver stalls the result is held
// in the output register, a new command is still accepted and run, and its
// result waits until the register is free.
module uniform_range_xorshift64star (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  urx_pkg::urx_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output urx_pkg::urx_out_t out_data_o
);

  urx_pkg::urx_state_e state_q, state_d;
  logic [63:0]         gen_q, gen_d;
  logic [63:0]         seed_q, seed_d;
  logic [63:0]         cnt_q, cnt_d;
  logic                lim_ok_q, lim_ok_d;
  logic                out_valid_q, out_valid_d;
  urx_pkg::urx_out_t   out_q, out_d;
  logic [31:0]         lo_q, lo_d;
  logic [urx_pkg::SpanW-1:0] span_q, span_d;
  logic [31:0]         res_q, res_d;

  logic                      mul_start, rem_start;
  logic [63:0]               mul_mcand, mul_word;
  logic [63:0]               rem_dvd;
  logic [urx_pkg::SpanW-1:0] rem_res;
  logic                      mul_busy, rem_busy;
  logic signed [31:0]        b_lo, b_hi;
  logic [urx_pkg::SpanW-1:0] diff;

  urx_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mul_mcand),
    .busy_o  (mul_busy),
    .word_o  (mul_word)
  );

  urx_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (span_q),
    .busy_o     (rem_busy),
    .rem_o      (rem_res)
  );

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    seed_d      = seed_q;
    cnt_d       = cnt_q;
    lim_ok_d    = lim_ok_q;
    lo_d        = lo_q;
    span_d      = span_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    mul_start   = 1'b0;
    mul_mcand   = urx_pkg::xs_step(gen_q);
    rem_start   = 1'b0;
    rem_dvd     = 64'd0 - {31'd0, span_q};
    if (in_data_i.range_high < in_data_i.range_low) begin
      b_lo = in_data_i.range_high;
      b_hi = in_data_i.range_low;
    end else begin
      b_lo = in_data_i.range_low;
      b_hi = in_data_i.range_high;
    end
    diff = {b_hi[31], b_hi} - {b_lo[31], b_lo};

    unique case (state_q)
      urx_pkg::UrxIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.cmd == urx_pkg::CmdReseed) begin
            seed_d  = (in_data_i.seed_value == 64'd0) ? urx_pkg::DefaultSeed
                                                      : in_data_i.seed_value;
            gen_d   = seed_d;
            cnt_d   = '0;
            res_d   = '0;
            state_d = urx_pkg::UrxEmit;
          end else begin
            lo_d     = b_lo;
            span_d   = diff + 1'b1;
            lim_ok_d = 1'b0;
            state_d  = urx_pkg::UrxStep;
          end
        end
      end
      urx_pkg::UrxStep: begin
        gen_d     = mul_mcand;
        cnt_d     = cnt_q + 64'd1;
        mul_start = 1'b1;
        rem_start = !lim_ok_q;
        lim_ok_d  = 1'b1;
        state_d   = urx_pkg::UrxMul;
      end
      urx_pkg::UrxMul: begin
        if (!mul_busy && !rem_busy) begin
          if (mul_word < {31'd0, rem_res}) begin
            state_d = urx_pkg::UrxStep;
          end else begin
            rem_dvd   = mul_word;
            rem_start = 1'b1;
            state_d   = urx_pkg::UrxMod;
          end
        end
      end
      urx_pkg::UrxMod: begin
        if (!rem_busy) begin
          res_d   = lo_q + rem_res[31:0];
          state_d = urx_pkg::UrxEmit;
        end
      end
      urx_pkg::UrxEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.drawn_value = res_q;
          out_d.state_now   = gen_q;
          out_d.seed_now    = seed_q;
          out_d.draw_total  = cnt_q;
          out_valid_d       = 1'b1;
          state_d           = urx_pkg::UrxIdle;
        end
      end
      default: state_d = urx_pkg::UrxIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= urx_pkg::UrxIdle;
      gen_q       <= urx_pkg::DefaultSeed;
      seed_q      <= urx_pkg::DefaultSeed;
      cnt_q       <= '0;
      lim_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      seed_q      <= seed_d;
      cnt_q       <= cnt_d;
      lim_ok_q    <= lim_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    lo_q   <= lo_d;
    span_q <= span_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/urx_checker.sv =====
module urx_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input urx_pkg::urx_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  a_seed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.seed_now != 64'd0)
    else $error("seed in use is zero");

  a_state_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.state_now != 64'd0)
    else $error("generator state is zero");

  a_fresh_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.draw_total == 64'd0
      |-> out_data_o.state_now == out_data_o.seed_now)
    else $error("state differs from seed with no steps taken");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule

bind uniform_range_xorshift64star urx_checker u_urx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== verif/uniform_range_xorshift64star_tb.sv =====
module uniform_range_xorshift64star_tb;

  class draw_scoreboard;
    logic [63:0]       gen_word;
    logic [63:0]       seed_word;
    logic [63:0]       step_total;
    urx_pkg::urx_out_t expected_draws[$];
    int                fails;
    int                checked;

    function new();
      gen_word   = urx_pkg::DefaultSeed;
      seed_word  = urx_pkg::DefaultSeed;
      step_total = '0;
      fails      = 0;
      checked    = 0;
    endfunction

    function void note_command(urx_pkg::urx_in_t cmd_item);
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic signed [31:0] tmp;
      logic [32:0]        diff;
      logic [63:0]        span;
      logic [63:0]        limit;
      logic [63:0]        word;
      logic [63:0]        s;
      logic [63:0]        total;
      urx_pkg::urx_out_t  res;
      res = '0;
      if (cmd_item.cmd == urx_pkg::CmdReseed) begin
        seed_word  = (cmd_item.seed_value != 64'd0) ? cmd_item.seed_value
                                                    : urx_pkg::DefaultSeed;
        gen_word   = seed_word;
        step_total = '0;
      end else begin
        lo = cmd_item.range_low;
        hi = cmd_item.range_high;
        if (hi < lo) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        diff  = {hi[31], hi} - {lo[31], lo};
        span  = {31'd0, diff} + 64'd1;
        limit = (64'd0 - span) % span;
        do begin
          s = gen_word;
          s = s ^ (s >> urx_pkg::ShiftA);
          s = s ^ (s << urx_pkg::ShiftB);
          s = s ^ (s >> urx_pkg::ShiftC);
          gen_word   = s;
          step_total = step_total + 64'd1;
          word       = s * urx_pkg::MixMult;
        end while (word < limit);
        total = {32'd0, lo} + (word % span);
        res.drawn_value = total[31:0];
      end
      res.state_now  = gen_word;
      res.seed_now   = seed_word;
      res.draw_total = step_total;
      expected_draws.push_back(res);
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s at result %0d: got %h, expected %h",
               field, checked, got, want);
      fails++;
    endtask

    task check_draw(urx_pkg::urx_out_t got);
      urx_pkg::urx_out_t want;
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected item", 64'(got.drawn_value), 64'd0);
      end else begin
        want = expected_draws.pop_front();
        if (got.drawn_value !== want.drawn_value)
          report_mismatch("drawn_value", 64'(got.drawn_value), 64'(want.drawn_value));
        if (got.state_now !== want.state_now)
          report_mismatch("state_now", got.state_now, want.state_now);
        if (got.seed_now !== want.seed_now)
          report_mismatch("seed_now", got.seed_now, want.seed_now);
        if (got.draw_total !== want.draw_total)
          report_mismatch("draw_total", got.draw_total, want.draw_total);
      end
      checked++;
    endtask
  endclass

  localparam logic signed [31:0] MinBound = 32'sh8000_0000;
  localparam logic signed [31:0] MaxBound = 32'sh7fff_ffff;
  localparam int unsigned        HoldCycles = 1500;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  urx_pkg::urx_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  urx_pkg::urx_out_t out_data_o;

  draw_scoreboard board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  uniform_range_xorshift64star dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_command(in_data_i);
      if (out_valid_o && out_ready_i) board.check_draw(out_data_o);
    end
  end

  task send_item(urx_pkg::urx_in_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task send_draw(logic signed [31:0] lo, logic signed [31:0] hi);
    urx_pkg::urx_in_t item;
    item.cmd        = urx_pkg::CmdDraw;
    item.range_low  = lo;
    item.range_high = hi;
    item.seed_value = {$urandom, $urandom};
    send_item(item);
  endtask

  task send_reseed(logic [63:0] seed);
    urx_pkg::urx_in_t item;
    item.cmd        = urx_pkg::CmdReseed;
    item.range_low  = $urandom;
    item.range_high = $urandom;
    item.seed_value = seed;
    send_item(item);
  endtask

  function automatic logic signed [31:0] extreme_bound();
    case ($urandom_range(0, 3))
      0: return MinBound;
      1: return MaxBound;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  task random_command();
    logic signed [31:0] a;
    logic signed [31:0] b;
    if ($urandom_range(0, 99) < 5) begin
      if ($urandom_range(0, 7) == 0) send_reseed(64'd0);
      else send_reseed({$urandom, $urandom});
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          a = $urandom;
          b = $urandom;
        end
        1: begin
          a = $urandom;
          b = a + 32'($urandom_range(0, 20));
        end
        2: begin
          a = extreme_bound();
          b = extreme_bound();
        end
        default: begin
          a = $urandom;
          b = a + 32'($urandom >> $urandom_range(0, 31));
        end
      endcase
      send_draw(a, b);
    end
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_draws.size() != 0) @(posedge clk_i);
  endtask

  task run_phase(int idle_pct, int stall_pct, int count, bit with_hold);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 10) hold_requests = hold_requests + 1;
      random_command();
    end
    wait_drained();
  endtask

  initial begin
    #(64'd60_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_draw(32'sd0, 32'sd0);
    send_draw(MinBound, MaxBound);
    send_draw(MaxBound, MinBound);
    send_draw(MinBound, MinBound);
    send_draw(MaxBound, MaxBound);
    send_draw(-32'sd1, 32'sd0);
    send_draw(32'sd10, -32'sd10);
    send_draw(32'sd0, 32'sd1);
    send_draw(MinBound, MinBound + 32'sd1);
    send_draw(MaxBound - 32'sd1, MaxBound);
    send_draw(32'sd0, 32'sd2);
    send_draw(MinBound, 32'sd0);
    send_reseed(64'd0);
    send_draw(32'sd1, 32'sd6);
    send_reseed({64{1'b1}});
    send_draw(MinBound, MaxBound);
    send_reseed(64'd1);
    send_draw(-32'sd100, 32'sd100);
    send_reseed(64'h8000_0000_0000_0000);
    send_draw(32'sd5, 32'sd5);
    send_reseed({$urandom, $urandom});
    wait_drained();

    run_phase(0, 0, 480, 1'b0);
    run_phase(60, 0, 480, 1'b0);
    run_phase(0, 60, 480, 1'b1);
    run_phase(8, 8, 480, 1'b0);

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/urx_pkg.sv
design/urx_rem.sv
design/urx_mul.sv
design/uniform_range_xorshift64star.sv
design/urx_checker.sv
verif/uniform_range_xorshift64star_tb.sv
